[src/psfp_pkg.sv]
package psfp_pkg;

    localparam int FRAME_LENGTH = 16;
    localparam int POS_W = 4;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LENGTH - 1);

    localparam logic [7:0] HEAD_FIRST = 8'h40;
    localparam logic [7:0] HEAD_SECOND = 8'h0d;

    localparam int DATA_COUNT = 8;
    localparam logic [POS_W-1:0] DATA_FIRST_POS = POS_W'(3);
    localparam logic [POS_W-1:0] DATA_LAST_POS = POS_W'(3 + DATA_COUNT - 1);

    typedef enum logic [1:0] {
        STATUS_OK           = 2'd0,
        STATUS_HEADER_ERR   = 2'd1,
        STATUS_CHECKSUM_ERR = 2'd2
    } status_t;

endpackage

[src/particle_sensor_frame_parser.sv]
// A result item appears on m_tvalid in the cycle after the input item that completes it.
// Throughput: one byte item per cycle; the single result register stalls s_tready only while
// a result item waits and m_tready is low.
// Reset: synchronous, active low; clears the byte position, running sum, header flag and
// the result valid flag. Captured data bytes are not reset.
module particle_sensor_frame_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [15:0] pm1, [31:16] pm2.5, [47:32] pm4, [63:48] pm10
    output logic [1:0]  m_tuser    // [1:0] status
);

    logic [psfp_pkg::POS_W-1:0] pos_reg, pos_next, pos_eff;
    logic [7:0]                 sum_reg, sum_next, sum_add;
    logic                       first_ok_reg, first_ok_next;
    logic [7:0]                 data_reg [psfp_pkg::DATA_COUNT];
    logic                       m_tvalid_reg, m_tvalid_next;
    logic [63:0]                m_tdata_reg, m_tdata_next;
    psfp_pkg::status_t          status_reg, status_next;
    logic                       s_accept;
    logic                       emit;
    logic [2:0]                 data_idx;
    logic                       data_we;
    logic [psfp_pkg::POS_W-1:0] data_off;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign pos_eff  = s_tuser ? '0 : pos_reg;
    assign sum_add  = sum_reg + s_tdata;
    assign data_off = pos_eff - psfp_pkg::DATA_FIRST_POS;
    assign data_idx = data_off[2:0];
    assign data_we  = s_accept && pos_eff >= psfp_pkg::DATA_FIRST_POS
                      && pos_eff <= psfp_pkg::DATA_LAST_POS;

    always_comb begin
        pos_next      = pos_reg;
        sum_next      = sum_reg;
        first_ok_next = first_ok_reg;
        emit          = 1'b0;
        status_next   = status_reg;
        m_tdata_next  = m_tdata_reg;
        if (pos_eff == '0) begin
            first_ok_next = (s_tdata == psfp_pkg::HEAD_FIRST);
            sum_next      = s_tdata;
            pos_next      = psfp_pkg::POS_W'(1);
        end else if (pos_eff == psfp_pkg::POS_W'(1)) begin
            if (!first_ok_reg || s_tdata != psfp_pkg::HEAD_SECOND) begin
                emit          = 1'b1;
                status_next   = psfp_pkg::STATUS_HEADER_ERR;
                m_tdata_next  = '0;
                pos_next      = '0;
                sum_next      = '0;
                first_ok_next = 1'b0;
            end else begin
                sum_next = sum_add;
                pos_next = psfp_pkg::POS_W'(2);
            end
        end else if (pos_eff >= psfp_pkg::LAST_POS) begin
            emit = 1'b1;
            if (sum_add == 8'd0) begin
                status_next  = psfp_pkg::STATUS_OK;
                m_tdata_next = {data_reg[6], data_reg[7], data_reg[4], data_reg[5],
                                data_reg[2], data_reg[3], data_reg[0], data_reg[1]};
            end else begin
                status_next  = psfp_pkg::STATUS_CHECKSUM_ERR;
                m_tdata_next = '0;
            end
            pos_next      = '0;
            sum_next      = '0;
            first_ok_next = 1'b0;
        end else begin
            sum_next = sum_add;
            pos_next = pos_eff + psfp_pkg::POS_W'(1);
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (s_accept && emit) begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            sum_reg      <= '0;
            first_ok_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            if (s_accept) begin
                pos_reg      <= pos_next;
                sum_reg      <= sum_next;
                first_ok_reg <= first_ok_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && emit) begin
            status_reg  <= status_next;
            m_tdata_reg <= m_tdata_next;
        end
        if (data_we) begin
            data_reg[data_idx] <= s_tdata;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = status_reg;

    a_header_err: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && !s_tuser && pos_reg == psfp_pkg::POS_W'(1)
        && (!first_ok_reg || s_tdata != psfp_pkg::HEAD_SECOND)
        |=> m_tvalid && m_tuser == psfp_pkg::STATUS_HEADER_ERR)
        else $error("header error item missing");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != psfp_pkg::STATUS_OK |-> m_tdata == '0)
        else $error("error item carries nonzero values");

    a_start_sync: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_tuser |=> pos_reg == psfp_pkg::POS_W'(1) && !m_tvalid
        && sum_reg == $past(s_tdata))
        else $error("start flag did not resynchronize");

    a_emit_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && emit |=> pos_reg == '0 && sum_reg == 8'd0 && !first_ok_reg)
        else $error("parser not rearmed after result");

endmodule
